// ----- design/sbm_pkg.sv -----
// sbm_pkg: field widths, address windows, copy constants and the result word type
// for the serial bank mapper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbm_pkg;

  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int DEST_W  = 16;
  localparam int SRC_W   = 23;
  localparam int LEN_W   = 16;
  localparam int BANKS_W = 8;

  localparam logic [BANKS_W-1:0] BANKS_RESET = 8'd2;

  // Address window codes, taken from address bits 14:13
  localparam logic [1:0] WIN_CTRL = 2'd0;
  localparam logic [1:0] WIN_CHR0 = 2'd1;
  localparam logic [1:0] WIN_CHR1 = 2'd2;
  localparam logic [1:0] WIN_PRG  = 2'd3;

  localparam int CLEAR_BIT  = 7;
  localparam int SERIAL_BIT = 0;

  localparam logic [SRC_W-1:0] HEADER_BYTES = 23'd16;

  // Bank sizes as shift amounts (log2 of bytes)
  localparam int SHIFT_4K  = 12;
  localparam int SHIFT_8K  = 13;
  localparam int SHIFT_16K = 14;
  localparam int SHIFT_32K = 15;

  localparam logic [LEN_W-1:0] LEN_4K  = 16'd4096;
  localparam logic [LEN_W-1:0] LEN_8K  = 16'd8192;
  localparam logic [LEN_W-1:0] LEN_16K = 16'd16384;
  localparam logic [LEN_W-1:0] LEN_32K = 16'd32768;

  localparam logic [DEST_W-1:0] DEST_PRG_LOW  = 16'h8000;
  localparam logic [DEST_W-1:0] DEST_PRG_HIGH = 16'hC000;
  localparam logic [DEST_W-1:0] DEST_CHR_LOW  = 16'h0000;
  localparam logic [DEST_W-1:0] DEST_CHR_HIGH = 16'h1000;

  localparam logic TARGET_PRG = 1'b0;
  localparam logic TARGET_CHR = 1'b1;

  typedef struct packed {
    logic              copy_valid;
    logic              copy_target;
    logic [DEST_W-1:0] dest_address;
    logic [SRC_W-1:0]  source_offset;
    logic [LEN_W-1:0]  copy_length;
    logic              mirroring;
    logic              one_screen;
  } copy_word_t;

endpackage

`default_nettype wire

// ----- design/sbm_ifs.sv -----
// Channel interfaces of the serial bank mapper: CPU write input, configuration
// write and copy request output. Depends on sbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sbm_cpu_if;
  logic                        valid;
  logic                        ready;
  logic [sbm_pkg::ADDR_W-1:0]  address;
  logic [sbm_pkg::DATA_W-1:0]  write_data;

  modport source (output valid, output address, output write_data, input ready);
  modport sink   (input valid, input address, input write_data, output ready);
endinterface

interface sbm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [sbm_pkg::BANKS_W-1:0] prg_rom_banks;

  modport source (output valid, output prg_rom_banks, input ready);
  modport sink   (input valid, input prg_rom_banks, output ready);
endinterface

interface sbm_copy_if;
  logic                        valid;
  logic                        ready;
  logic                        copy_valid;
  logic                        copy_target;
  logic [sbm_pkg::DEST_W-1:0]  dest_address;
  logic [sbm_pkg::SRC_W-1:0]   source_offset;
  logic [sbm_pkg::LEN_W-1:0]   copy_length;
  logic                        mirroring;
  logic                        one_screen;

  modport source (output valid, output copy_valid, output copy_target,
                  output dest_address, output source_offset, output copy_length,
                  output mirroring, output one_screen, input ready);
  modport sink   (input valid, input copy_valid, input copy_target,
                  input dest_address, input source_offset, input copy_length,
                  input mirroring, input one_screen, output ready);
endinterface

`default_nettype wire

// ----- design/sbm_out_buf.sv -----
// sbm_out_buf: two-entry result buffer that decouples the mapper from a
// stalling receiver. Depends on sbm_pkg for the result word type.
`timescale 1ns / 1ps
`default_nettype none

module sbm_out_buf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire sbm_pkg::copy_word_t push_word,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sbm_pkg::copy_word_t      out_word
);

  sbm_pkg::copy_word_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_word  = entries[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("result buffer occupancy out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full result buffer");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("pointers disagree with occupancy");

endmodule

`default_nettype wire

// ----- design/serial_bank_mapper.sv -----
// serial_bank_mapper: top level. Serial bank registers, control flags and copy
// request generation. Depends on sbm_pkg, sbm_ifs and sbm_out_buf.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   cpu  : one CPU bus write per word (address, write_data). Writes at 0x8000
//          and above shift bit 0 into the serial register of their 8 KiB
//          window; bit 7 set clears that register instead.
//   copy : exactly one result word per CPU write, in order. copy_valid marks a
//          committed PRG or nonzero CHR bank switch with its destination, image
//          offset and length; mirroring and one_screen always show the current flags.
//   cfg  : writes prg_rom_banks; always ready. Write it only while idle.
// Timing
//   Each write is decoded and its register state updated in the cycle it is
//   accepted; its result word is registered in the result buffer and shown once
//   older words have left. One write per cycle while the result buffer is not full.
// Reset
//   rst (synchronous) clears all shift registers and flags, empties the
//   result buffer and sets prg_rom_banks to 2.
// Stalls
//   A two-entry result buffer keeps cpu ready while one result waits; cpu
//   ready drops only when both entries are held by a stalled receiver.

module serial_bank_mapper #(
  parameter int SERIAL_BITS = 5
) (
  input  wire logic   clk,
  input  wire logic   rst,
  sbm_cpu_if.sink     cpu,
  sbm_cfg_if.sink     cfg,
  sbm_copy_if.source  copy
);

  localparam int SW = SERIAL_BITS;
  localparam int CW = $clog2(SERIAL_BITS + 1);
  localparam int PW = sbm_pkg::SRC_W - SW;

  // Serial registers, one per window
  logic [SW-1:0] shift_value [4];
  logic [CW-1:0] shift_count [4];

  // Control flags
  logic prg_area_flag;
  logic prg_small_pages;
  logic chr_small_pages;
  logic mirror_mode;
  logic single_screen;

  logic [sbm_pkg::BANKS_W-1:0] prg_rom_banks;

  // Decode
  logic          accept;
  logic          buf_full;
  logic          high_window;
  logic [1:0]    win;
  logic          clear_req;
  logic          serial_bit;
  logic [SW-1:0] cur_value;
  logic [CW-1:0] cur_count;
  logic [SW-1:0] shifted_value;
  logic [CW:0]   count_inc;
  logic          commit;
  logic [SW-1:0] val;
  logic          ctrl_commit;
  logic [sbm_pkg::SRC_W-1:0] val_ext;
  logic [sbm_pkg::SRC_W-1:0] chr_base;

  sbm_pkg::copy_word_t res;
  sbm_pkg::copy_word_t out_word;
  logic                out_valid;

  assign accept      = cpu.valid && cpu.ready;
  assign cpu.ready   = !buf_full;
  assign cfg.ready   = 1'b1;

  assign high_window = cpu.address[sbm_pkg::ADDR_W-1];
  assign win         = cpu.address[sbm_pkg::ADDR_W-2:sbm_pkg::ADDR_W-3];
  assign clear_req   = cpu.write_data[sbm_pkg::CLEAR_BIT];
  assign serial_bit  = cpu.write_data[sbm_pkg::SERIAL_BIT];
  assign cur_value   = shift_value[win];
  assign cur_count   = shift_count[win];

  // Shift the serial bit in at the current count
  always_comb begin
    shifted_value = cur_value;
    if ({1'b0, cur_count} < (CW + 1)'(SW)) begin
      shifted_value = cur_value | (SW'(serial_bit) << cur_count);
    end
  end

  assign count_inc   = {1'b0, cur_count} + (CW + 1)'(1);
  assign commit      = high_window && !clear_req && (count_inc >= (CW + 1)'(SW));
  assign val         = shifted_value;
  assign ctrl_commit = commit && (win == sbm_pkg::WIN_CTRL);
  assign val_ext     = {{PW{1'b0}}, val};
  assign chr_base    = sbm_pkg::HEADER_BYTES
                     + (sbm_pkg::SRC_W'(prg_rom_banks) << sbm_pkg::SHIFT_16K);

  // Build the result word
  always_comb begin
    res               = '0;
    res.mirroring     = ctrl_commit ? !val[0] : mirror_mode;
    res.one_screen    = ctrl_commit ? val[1] : single_screen;
    if (commit) begin
      case (win)
        sbm_pkg::WIN_PRG: begin
          res.copy_valid    = 1'b1;
          res.copy_target   = sbm_pkg::TARGET_PRG;
          res.copy_length   = prg_small_pages ? sbm_pkg::LEN_16K : sbm_pkg::LEN_32K;
          res.dest_address  = (prg_small_pages && !prg_area_flag) ?
                              sbm_pkg::DEST_PRG_HIGH : sbm_pkg::DEST_PRG_LOW;
          res.source_offset = sbm_pkg::HEADER_BYTES + (prg_small_pages ?
                              (val_ext << sbm_pkg::SHIFT_16K) :
                              (val_ext << sbm_pkg::SHIFT_32K));
        end
        sbm_pkg::WIN_CHR0, sbm_pkg::WIN_CHR1: begin
          if (val != '0) begin
            res.copy_valid    = 1'b1;
            res.copy_target   = sbm_pkg::TARGET_CHR;
            res.copy_length   = chr_small_pages ? sbm_pkg::LEN_4K : sbm_pkg::LEN_8K;
            res.dest_address  = (chr_small_pages && (win == sbm_pkg::WIN_CHR1)) ?
                                sbm_pkg::DEST_CHR_HIGH : sbm_pkg::DEST_CHR_LOW;
            res.source_offset = chr_base + (chr_small_pages ?
                                (val_ext << sbm_pkg::SHIFT_4K) :
                                (val_ext << sbm_pkg::SHIFT_8K));
          end
        end
        default: begin
          res.copy_valid = 1'b0;
        end
      endcase
    end
  end

  // Update serial registers and flags on each accepted write at 0x8000 and above
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        shift_value[i] <= '0;
        shift_count[i] <= '0;
      end
      prg_area_flag   <= 1'b0;
      prg_small_pages <= 1'b0;
      chr_small_pages <= 1'b0;
      mirror_mode     <= 1'b0;
      single_screen   <= 1'b0;
    end else if (accept && high_window) begin
      if (clear_req || commit) begin
        shift_value[win] <= '0;
        shift_count[win] <= '0;
      end else begin
        shift_value[win] <= shifted_value;
        shift_count[win] <= count_inc[CW-1:0];
      end
      if (ctrl_commit) begin
        mirror_mode     <= !val[0];
        single_screen   <= val[1];
        prg_area_flag   <= val[2];
        prg_small_pages <= val[3];
        chr_small_pages <= val[4];
      end
    end
  end

  // Hold the bank count register
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_rom_banks <= sbm_pkg::BANKS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      prg_rom_banks <= cfg.prg_rom_banks;
    end
  end

  sbm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (copy.ready),
    .out_word  (out_word)
  );

  assign copy.valid         = out_valid;
  assign copy.copy_valid    = out_word.copy_valid;
  assign copy.copy_target   = out_word.copy_target;
  assign copy.dest_address  = out_word.dest_address;
  assign copy.source_offset = out_word.source_offset;
  assign copy.copy_length   = out_word.copy_length;
  assign copy.mirroring     = out_word.mirroring;
  assign copy.one_screen    = out_word.one_screen;

  a_count_below_commit: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, shift_count[0]} < (CW + 1)'(SW)) && ({1'b0, shift_count[1]} < (CW + 1)'(SW)) &&
    ({1'b0, shift_count[2]} < (CW + 1)'(SW)) && ({1'b0, shift_count[3]} < (CW + 1)'(SW)))
    else $error("serial count reached commit without clearing");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && high_window && clear_req && (win == sbm_pkg::WIN_PRG)
    |=> (shift_count[3] == '0) && (shift_value[3] == '0))
    else $error("clear write left PRG serial register loaded");

  a_low_write_no_effect: assert property (@(posedge clk) disable iff (rst)
    accept && !high_window |=> $stable(mirror_mode) && $stable(prg_small_pages) &&
    $stable(chr_small_pages))
    else $error("write below window changed control flags");

  a_prg_dest: assert property (@(posedge clk) disable iff (rst)
    copy.valid && copy.copy_valid && (copy.copy_target == sbm_pkg::TARGET_PRG)
    |-> (copy.dest_address == sbm_pkg::DEST_PRG_LOW) ||
        (copy.dest_address == sbm_pkg::DEST_PRG_HIGH))
    else $error("PRG copy to bad destination");

endmodule

`default_nettype wire

// ----- verif/serial_bank_mapper_tb.sv -----
// serial_bank_mapper_tb: self-checking bench for the serial bank mapper. It predicts
// every copy word from the CPU writes and the bank count register.
// Depends on sbm_pkg, sbm_ifs and the serial_bank_mapper RTL.
`timescale 1ns / 1ps

module serial_bank_mapper_tb;

  localparam int SERIAL_BITS    = 5;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_WRITES   = 280;

  typedef struct packed {
    logic [sbm_pkg::ADDR_W-1:0] address;
    logic [sbm_pkg::DATA_W-1:0] data;
  } cpu_write_t;

  logic clk;
  logic rst;

  sbm_cpu_if  cpu_bus ();
  sbm_cfg_if  cfg_bus ();
  sbm_copy_if copy_bus ();

  serial_bank_mapper #(.SERIAL_BITS(SERIAL_BITS)) uut (
    .clk  (clk),
    .rst  (rst),
    .cpu  (cpu_bus),
    .cfg  (cfg_bus),
    .copy (copy_bus)
  );

  // Pending CPU writes and the copy words they should produce
  cpu_write_t          pending_writes[$];
  sbm_pkg::copy_word_t expected_copies[$];

  // Mirror of the mapper state
  logic [sbm_pkg::BANKS_W-1:0] banks_cfg;
  logic [4:0]                  serial_bits [4];
  logic [2:0]                  serial_count [4];
  logic                        area_flag;
  logic                        prg_half_pages;
  logic                        chr_half_pages;
  logic                        mirror_flag;
  logic                        single_flag;

  int sender_idle_pct;
  int receiver_idle_pct;
  int hold_requests;
  int hold_served;
  int hold_left;
  int mismatch_count;
  int idle_cycles;
  int queued_writes;
  int checked_writes;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one CPU write to the mirrored state and return the copy word it causes
  function automatic sbm_pkg::copy_word_t predict_copy(
      input logic [sbm_pkg::ADDR_W-1:0] addr,
      input logic [sbm_pkg::DATA_W-1:0] data);
    sbm_pkg::copy_word_t w;
    logic [1:0] win;
    int         cnt;
    int         val;
    int         len;
    logic       commit;
    w      = '0;
    commit = 1'b0;
    val    = 0;
    win    = addr[14:13];
    if (addr[15]) begin
      if (data[sbm_pkg::CLEAR_BIT]) begin
        serial_bits[win]  = '0;
        serial_count[win] = '0;
      end else begin
        cnt = serial_count[win];
        if (cnt < SERIAL_BITS)
          serial_bits[win] = serial_bits[win] | (5'(data[sbm_pkg::SERIAL_BIT]) << cnt);
        cnt++;
        if (cnt >= SERIAL_BITS) begin
          commit            = 1'b1;
          val               = serial_bits[win];
          serial_bits[win]  = '0;
          serial_count[win] = '0;
        end else begin
          serial_count[win] = 3'(cnt);
        end
      end
    end
    if (commit) begin
      if (win == sbm_pkg::WIN_CTRL) begin
        mirror_flag    = ~val[0];
        single_flag    = val[1];
        area_flag      = val[2];
        prg_half_pages = val[3];
        chr_half_pages = val[4];
      end else if (win == sbm_pkg::WIN_PRG) begin
        len             = prg_half_pages ? int'(sbm_pkg::LEN_16K) : int'(sbm_pkg::LEN_32K);
        w.copy_valid    = 1'b1;
        w.copy_target   = sbm_pkg::TARGET_PRG;
        w.dest_address  = (prg_half_pages && !area_flag) ?
                          sbm_pkg::DEST_PRG_HIGH : sbm_pkg::DEST_PRG_LOW;
        w.source_offset = sbm_pkg::HEADER_BYTES + sbm_pkg::SRC_W'(val * len);
        w.copy_length   = sbm_pkg::LEN_W'(len);
      end else if (val != 0) begin
        len             = chr_half_pages ? int'(sbm_pkg::LEN_4K) : int'(sbm_pkg::LEN_8K);
        w.copy_valid    = 1'b1;
        w.copy_target   = sbm_pkg::TARGET_CHR;
        w.dest_address  = (chr_half_pages && win == sbm_pkg::WIN_CHR1) ?
                          sbm_pkg::DEST_CHR_HIGH : sbm_pkg::DEST_CHR_LOW;
        w.source_offset = sbm_pkg::HEADER_BYTES +
                          sbm_pkg::SRC_W'(int'(sbm_pkg::LEN_16K) * banks_cfg + val * len);
        w.copy_length   = sbm_pkg::LEN_W'(len);
      end
    end
    w.mirroring  = mirror_flag;
    w.one_screen = single_flag;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic push_write(input logic [sbm_pkg::ADDR_W-1:0] addr,
                            input logic [sbm_pkg::DATA_W-1:0] data);
    cpu_write_t w;
    w.address = addr;
    w.data    = data;
    pending_writes.push_back(w);
    queued_writes++;
  endtask

  // Five serial writes that load value into the window of addr
  task automatic push_serial(input logic [sbm_pkg::ADDR_W-1:0] addr, input logic [4:0] value,
                             input logic [5:0] filler);
    int b;
    for (b = 0; b < SERIAL_BITS; b++)
      push_write(addr, {1'b0, filler, value[b]});
  endtask

  // Mostly complete serial loads with random content; some clears and stray writes
  task automatic push_random_writes(input int count);
    int         goal;
    int         pick;
    int         b;
    logic [1:0] win;
    logic [4:0] value;
    goal = queued_writes + count;
    while (queued_writes < goal) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        push_write({1'b0, 15'($urandom)}, 8'($urandom));
      end else if (pick < 20) begin
        push_write({1'b1, 15'($urandom)}, 8'($urandom));
      end else begin
        win   = 2'($urandom);
        value = 5'($urandom);
        if ($urandom_range(4) == 0)
          push_write({1'b1, win, 13'($urandom)}, 8'h80 | 8'($urandom));
        for (b = 0; b < SERIAL_BITS; b++)
          push_write({1'b1, win, 13'($urandom)}, {1'b0, 6'($urandom), value[b]});
      end
    end
  endtask

  // Wait until every queued write has come back as a copy word
  task automatic wait_drained();
    while (checked_writes < queued_writes)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_banks(input logic [sbm_pkg::BANKS_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid         <= 1'b1;
    cfg_bus.prg_rom_banks <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    banks_cfg = value;
    cfg_bus.valid <= 1'b0;
  endtask

  // Offer the next write when the bus is free, predict each accepted word
  always @(posedge clk) begin : cpu_driver
    cpu_write_t w;
    if (rst) begin
      cpu_bus.valid <= 1'b0;
    end else begin
      if (cpu_bus.valid && cpu_bus.ready)
        expected_copies.push_back(predict_copy(cpu_bus.address, cpu_bus.write_data));
      if (!cpu_bus.valid || cpu_bus.ready) begin
        if (pending_writes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          w = pending_writes.pop_front();
          cpu_bus.valid      <= 1'b1;
          cpu_bus.address    <= w.address;
          cpu_bus.write_data <= w.data;
        end else begin
          cpu_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Check each copy word against the oldest expectation; drive ready
  always @(posedge clk) begin : copy_monitor
    sbm_pkg::copy_word_t want;
    if (rst) begin
      copy_bus.ready <= 1'b0;
    end else begin
      if (copy_bus.valid && copy_bus.ready) begin
        checked_writes++;
        if (expected_copies.size() == 0) begin
          $display("%0t: copy word with nothing expected, actual copy_valid %0b", $time,
                   copy_bus.copy_valid);
          mismatch_count++;
        end else begin
          want = expected_copies.pop_front();
          check_field("copy_valid", want.copy_valid, copy_bus.copy_valid);
          check_field("copy_target", want.copy_target, copy_bus.copy_target);
          check_field("dest_address", want.dest_address, copy_bus.dest_address);
          check_field("source_offset", want.source_offset, copy_bus.source_offset);
          check_field("copy_length", want.copy_length, copy_bus.copy_length);
          check_field("mirroring", want.mirroring, copy_bus.mirroring);
          check_field("one_screen", want.one_screen, copy_bus.one_screen);
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        copy_bus.ready <= 1'b0;
      end else begin
        copy_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Abort when no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (cpu_bus.valid && cpu_bus.ready) || (copy_bus.valid && copy_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("serial_bank_mapper_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int i;
    rst                   = 1'b1;
    cpu_bus.valid         = 1'b0;
    cpu_bus.address       = '0;
    cpu_bus.write_data    = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.prg_rom_banks = '0;
    copy_bus.ready        = 1'b0;
    banks_cfg             = sbm_pkg::BANKS_RESET;
    for (i = 0; i < 4; i++) begin
      serial_bits[i]  = '0;
      serial_count[i] = '0;
    end
    area_flag         = 1'b0;
    prg_half_pages    = 1'b0;
    chr_half_pages    = 1'b0;
    mirror_flag       = 1'b0;
    single_flag       = 1'b0;
    sender_idle_pct   = 14;
    receiver_idle_pct = 59;
    hold_requests     = 0;
    hold_served       = 0;
    hold_left         = 0;
    mismatch_count    = 0;
    idle_cycles       = 0;
    queued_writes     = 0;
    checked_writes    = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray low writes, full control load, clear mid-load,
    // CHR bank zero skipped, PRG bank zero copied, top CHR1 bank
    push_write(16'h7FFF, 8'hFF);
    push_write(16'h0000, 8'h01);
    push_serial(16'h9FFF, 5'h1F, 6'h3F);
    push_write(16'hBFFF, 8'h01);
    push_write(16'hA123, 8'h01);
    push_write(16'hA000, 8'hFF);
    push_serial(16'hA000, 5'h00, 6'h00);
    push_serial(16'hFFFF, 5'h00, 6'h15);
    push_serial(16'hDFFF, 5'h1F, 6'h2A);
    wait_drained();

    write_banks(8'hFF);
    push_random_writes(PHASE_WRITES);
    wait_drained();

    // Swap idling: sender slow, receiver mostly ready
    sender_idle_pct   = 59;
    receiver_idle_pct = 14;
    write_banks(8'h00);
    push_random_writes(PHASE_WRITES);
    wait_drained();

    // No idling; hold the receiver off so the result buffer fills
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    write_banks(8'($urandom_range(1, 254)));
    @(posedge clk);
    hold_requests <= hold_requests + 1;
    push_random_writes(PHASE_WRITES);
    wait_drained();

    write_banks(8'h80);
    push_random_writes(PHASE_WRITES);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_copies.size() == 0) begin
      $display("serial_bank_mapper_tb passed");
    end else begin
      $display("serial_bank_mapper_tb failed");
    end
    $finish;
  end

endmodule
